// ===== rtl/flw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flw_pkg
// Shared constants, codes and types of the four-level page table walker.
// ----------------------------------------------------------------------------
package flw_pkg;

    localparam int unsigned TABLE_WORDS_DEF = 4096;

    localparam int unsigned DIR_W       = 52;   // dir_base and phys_addr
    localparam int unsigned SIZE_W      = 16;   // mem_size
    localparam int unsigned SIZE_WORDS_W = SIZE_W - 3;
    localparam int unsigned VA_W        = 48;
    localparam int unsigned WIDX_W      = 12;   // word_index
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned LARGE_SHIFT = 21;
    localparam int unsigned FRAME_W     = DIR_W - PAGE_SHIFT;
    localparam int unsigned LVL_IDX_W   = 9;
    localparam int unsigned LVL0_SHIFT  = 39;
    localparam int unsigned PRESENT_BIT = 0;
    localparam int unsigned PS_BIT      = 7;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    localparam logic CFG_DIR_BASE = 1'b0;
    localparam logic CFG_MEM_SIZE = 1'b1;

    localparam logic [1:0] LVL_TOP   = 2'd0;
    localparam logic [1:0] LVL_DIR   = 2'd2;
    localparam logic [1:0] LVL_TABLE = 2'd3;

    typedef enum logic [1:0] {
        FK_NONE,
        FK_BEYOND,
        FK_NOT_PRESENT
    } fault_t;

    typedef struct packed {
        logic [1:0]       fault_level;
        fault_t           fault_kind;
        logic             large_page;
        logic             mapped;
        logic [DIR_W-1:0] phys_addr;
    } result_t;

    // 9-bit table index of vaddr for one level
    function automatic logic [LVL_IDX_W-1:0] lvl_index(input logic [VA_W-1:0] va,
                                                      input logic [1:0] lvl);
        logic [VA_W-1:0] sh;
        sh = va >> (LVL0_SHIFT - LVL_IDX_W * 32'(lvl));
        return sh[LVL_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/four_level_page_table_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walk of 48-bit virtual addresses over a table memory.
// ----------------------------------------------------------------------------
// Table words are loaded with write words (tuser = 0) and translations are
// requested with tuser = 1; every input word gives exactly one result word.
// A translation checks and issues the top-level read when it is accepted,
// then checks each returned table entry and issues the next read: a 2 MiB
// mapping reads three entries, a 4 KiB mapping four, fewer when it faults
// early. This is set by the chain of dependent reads from the single-port
// table memory; the check of each next entry runs in the same cycle as the
// returned data. After reset the table memory is cleared by a pass over all
// TABLE_WORDS words, during which no input word is taken; configuration
// writes are taken at any time. A finished result moves into the output
// register, or into one pending slot that stalls input until it drains.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
    parameter int unsigned TABLE_WORDS = flw_pkg::TABLE_WORDS_DEF,
    localparam int unsigned IDX_W = $clog2(TABLE_WORDS)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // configuration: index 0 dir_base, index 1 mem_size
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [flw_pkg::DIR_W-1:0] cfg_data,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // vaddr[47:0], word_index[59:48], word_data[123:60], zero pad [127:124]
    input  wire logic [127:0] s_axis_tdata,
    // func[0]
    input  wire logic         s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // phys_addr[51:0], mapped[52], large_page[53], fault_kind[55:54],
    // fault_level[57:56], zero pad [63:58]
    output logic [63:0]       m_axis_tdata
);
    import flw_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // ---- state ----
    state_t              state_reg;
    logic [IDX_W-1:0]    clr_idx_reg;
    logic [1:0]          level_reg;     // level of the entry being read
    logic [VA_W-1:0]     vaddr_reg;
    logic [DIR_W-1:0]    dir_base_reg;
    logic [SIZE_W-1:0]   mem_size_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             pend_reg;
    logic [WORD_W-1:0]   rd_q_reg;      // registered table read data

    // table memory
    logic [WORD_W-1:0]   table_mem [TABLE_WORDS];

    // ---- input fields ----
    logic                in_func;
    logic [VA_W-1:0]     in_vaddr;
    logic [WIDX_W-1:0]   in_word_index;
    logic [WORD_W-1:0]   in_word_data;
    logic                in_accept;
    logic                in_range;

    assign in_func       = s_axis_tuser;
    assign in_vaddr      = s_axis_tdata[47:0];
    assign in_word_index = s_axis_tdata[59:48];
    assign in_word_data  = s_axis_tdata[123:60];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_range      = 32'(in_word_index) < 32'(TABLE_WORDS);

    // ---- next entry address and bound check ----
    logic [FRAME_W-1:0]   chk_frame;
    logic [LVL_IDX_W-1:0] chk_idx;
    logic [IDX_W-1:0]     chk_word;
    logic                 chk_beyond;

    // idle: top-level entry from dir_base; walking: next level from read data
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            chk_frame = dir_base_reg[DIR_W-1:PAGE_SHIFT];
            chk_idx   = lvl_index(in_vaddr, LVL_TOP);
        end
        else
        begin
            chk_frame = rd_q_reg[DIR_W-1:PAGE_SHIFT];
            chk_idx   = lvl_index(vaddr_reg, level_reg + 2'd1);
        end
    end

    flw_entry_addr #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_entry_addr (
        .mem_size  (mem_size_reg),
        .frame     (chk_frame),
        .idx       (chk_idx),
        .word_addr (chk_word),
        .beyond    (chk_beyond)
    );

    // ---- walk decisions ----
    logic    out_free;
    logic    out_load;   // output register takes a result this cycle
    logic    done;       // a result is ready this cycle
    logic    walk_go;    // issue the next entry read
    logic    tbl_we;
    result_t res;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        done    = 1'b0;
        walk_go = 1'b0;
        tbl_we  = 1'b0;
        res     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_func == FUNC_WRITE)
                    begin
                        done   = 1'b1;
                        tbl_we = in_range;
                    end
                    else if (chk_beyond)
                    begin
                        done            = 1'b1;
                        res.fault_kind  = FK_BEYOND;
                        res.fault_level = LVL_TOP;
                    end
                    else
                    begin
                        walk_go = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (!rd_q_reg[PRESENT_BIT])
                begin
                    done            = 1'b1;
                    res.fault_kind  = FK_NOT_PRESENT;
                    res.fault_level = level_reg;
                end
                else if (level_reg == LVL_DIR && rd_q_reg[PS_BIT])
                begin
                    // 2 MiB page
                    done           = 1'b1;
                    res.mapped     = 1'b1;
                    res.large_page = 1'b1;
                    res.phys_addr  = {rd_q_reg[DIR_W-1:LARGE_SHIFT],
                                      vaddr_reg[LARGE_SHIFT-1:0]};
                end
                else if (level_reg == LVL_TABLE)
                begin
                    // 4 KiB page
                    done          = 1'b1;
                    res.mapped    = 1'b1;
                    res.phys_addr = {rd_q_reg[DIR_W-1:PAGE_SHIFT],
                                     vaddr_reg[PAGE_SHIFT-1:0]};
                end
                else if (chk_beyond)
                begin
                    done            = 1'b1;
                    res.fault_kind  = FK_BEYOND;
                    res.fault_level = level_reg + 2'd1;
                end
                else
                begin
                    walk_go = 1'b1;
                end
            end
            ST_FINISH:
            begin
                done = 1'b0;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // a fresh result or the pending one moves into a free output register
    assign out_load = out_free && (done || state_reg == ST_FINISH);

    // ---- table memory: one write or one read per cycle ----
    logic [IDX_W-1:0]  tbl_waddr;
    logic [WORD_W-1:0] tbl_wdata;

    assign tbl_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : IDX_W'(in_word_index);
    assign tbl_wdata = (state_reg == ST_CLEAR) ? '0 : in_word_data;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            table_mem[tbl_waddr] <= tbl_wdata;
        if (walk_go)
            rd_q_reg <= table_mem[chk_word];
    end

    // ---- control, config and result registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            level_reg     <= LVL_TOP;
            vaddr_reg     <= '0;
            dir_base_reg  <= '0;
            mem_size_reg  <= SIZE_W'(32768);
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIR_BASE: dir_base_reg <= cfg_data;
                    CFG_MEM_SIZE: mem_size_reg <= cfg_data[SIZE_W-1:0];
                    default:      mem_size_reg <= mem_size_reg;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    if (clr_idx_reg == IDX_W'(TABLE_WORDS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE, ST_WALK:
                begin
                    if (walk_go)
                    begin
                        state_reg <= ST_WALK;
                        if (state_reg == ST_IDLE)
                        begin
                            vaddr_reg <= in_vaddr;
                            level_reg <= LVL_TOP;
                        end
                        else
                        begin
                            level_reg <= level_reg + 2'd1;
                        end
                    end
                    else if (done)
                    begin
                        if (out_free)
                        begin
                            out_reg   <= res;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            pend_reg  <= res;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_reg   <= pend_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.fault_level, out_reg.fault_kind,
                            out_reg.large_page, out_reg.mapped, out_reg.phys_addr};

endmodule
`default_nettype wire

// ===== rtl/flw_entry_addr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flw_entry_addr
// Word address of a table entry and its bound check against the readable size.
// ----------------------------------------------------------------------------
module flw_entry_addr #(
    parameter int unsigned TABLE_WORDS = flw_pkg::TABLE_WORDS_DEF,
    localparam int unsigned IDX_W = $clog2(TABLE_WORDS)
) (
    input  wire logic [flw_pkg::SIZE_W-1:0]    mem_size,
    input  wire logic [flw_pkg::FRAME_W-1:0]   frame,
    input  wire logic [flw_pkg::LVL_IDX_W-1:0] idx,
    output logic      [IDX_W-1:0]              word_addr,
    output logic                               beyond
);
    import flw_pkg::*;

    localparam int unsigned LIM_W   = $clog2(TABLE_WORDS + 1);
    localparam int unsigned WFULL_W = FRAME_W + LVL_IDX_W;

    logic [SIZE_WORDS_W-1:0] size_words;
    logic [LIM_W-1:0]        lim;
    logic [WFULL_W-1:0]      word_full;

    // 8*k > size  <=>  k > size/8, so an entry at word w faults when w >= lim
    assign size_words = mem_size[SIZE_W-1:3];

    always_comb
    begin
        if (32'(size_words) > 32'(TABLE_WORDS))
            lim = LIM_W'(TABLE_WORDS);
        else
            lim = LIM_W'(size_words);
    end

    assign word_full = {frame, idx};
    assign beyond    = word_full >= WFULL_W'(lim);
    assign word_addr = word_full[IDX_W-1:0];

endmodule
`default_nettype wire
